// ----- rtl/tile_depth_rasterizer_core_defines.svh -----
// ---------------------------------------------------------------------------
// Tile depth rasterizer assertion macros
// Shared property forms for the concurrent checks of the rasterizer core.
// ---------------------------------------------------------------------------
`ifndef TILE_DEPTH_RASTERIZER_CORE_DEFINES_SVH
`define TILE_DEPTH_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked on the core clock outside reset.
`define TDR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the core clock outside reset.
`define TDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tdr_pkg.sv -----
// ---------------------------------------------------------------------------
// Tile depth rasterizer package
// Shared constants, codes and types of the rasterizer core and its divider.
// ---------------------------------------------------------------------------
package tdr_pkg;

    localparam int TILE_W_DEF   = 32;
    localparam int TILE_H_DEF   = 32;
    localparam int COARSE_W_DEF = 8;
    localparam int COARSE_H_DEF = 8;

    localparam int DEPTH_W  = 25;
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = 25'h1000000;
    localparam int CRD_W    = 18;
    localparam int NUM_W    = 58;
    localparam int QUO_W    = 26;
    localparam int Q_W      = 28;
    localparam int ORG_W    = 12;
    localparam int SCR_W    = 13;
    localparam logic [SCR_W-1:0] SCR_W_RST = 13'd1024;
    localparam logic [SCR_W-1:0] SCR_H_RST = 13'd512;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_DRAW  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_BLOCK = 2'd3
    } t_mode;

    typedef enum logic {
        REG_SCREEN_W = 1'b0,
        REG_SCREEN_H = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        ACC_AREA = 2'd0,
        ACC_E0   = 2'd1,
        ACC_E1   = 2'd2,
        ACC_E2   = 2'd3
    } t_acc;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_CHECK,
        S_EDGE,
        S_MUL,
        S_NUM,
        S_DIV,
        S_WB,
        S_READ,
        S_BLOCK,
        S_BDRAIN,
        S_OUT
    } t_state;

endpackage

// ----- rtl/tdr_divider.sv -----
// ---------------------------------------------------------------------------
// Tile depth rasterizer divider
// Floor division of a signed numerator by a positive area, one quotient bit
// per cycle, with the quotient saturated just beyond the useful depth range.
// ---------------------------------------------------------------------------
module tdr_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tdr_pkg::NUM_W-1:0]    i_num,
    input  logic        [30:0]                  i_den,
    output logic                                o_done,
    output logic signed [tdr_pkg::Q_W-1:0]      o_quo
);

    localparam int AB_W = tdr_pkg::NUM_W - 1;
    localparam int QW   = tdr_pkg::QUO_W;
    localparam int CW   = $clog2(QW);
    localparam int SW   = tdr_pkg::Q_W;
    localparam logic signed [SW-1:0] QSAT = SW'(1) <<< QW;

    logic [AB_W-1:0] w_abs;
    logic            w_ovf;
    logic [AB_W-1:0] r_rem;
    logic [AB_W-1:0] r_dsh;
    logic [QW-1:0]   r_q;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic            r_neg;
    logic            r_ovf;
    logic [SW-1:0]   w_qx;
    logic [SW-1:0]   w_qr;

    always_comb begin
        w_abs = i_num[tdr_pkg::NUM_W-1] ? AB_W'(-i_num) : AB_W'(i_num);
        w_ovf = (w_abs[AB_W-1:QW] >= i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= !w_ovf;
            r_done <= w_ovf;
        end else if (r_busy) begin
            r_busy <= (r_cnt != '0);
            r_done <= (r_cnt == '0);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[tdr_pkg::NUM_W-1];
            r_ovf <= w_ovf;
            r_rem <= w_abs;
            r_dsh <= AB_W'({i_den, {(QW-1){1'b0}}});
            r_q   <= '0;
            r_cnt <= CW'(QW - 1);
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_comb begin
        w_qx = SW'(r_q);
        w_qr = w_qx + SW'(|r_rem);
        if (r_ovf) begin
            o_quo = r_neg ? -QSAT : QSAT;
        end else begin
            o_quo = r_neg ? $signed(-w_qr) : $signed(w_qx);
        end
    end

    assign o_done = r_done;

endmodule

// ----- rtl/tile_depth_rasterizer_core.sv -----
// ---------------------------------------------------------------------------
// Tile depth rasterizer core
// Keeps the maximum depth per pixel of one screen tile in an on-chip RAM.
// ---------------------------------------------------------------------------
// One word is taken at a time. After reset, and for every tile selection, a
// clearing pass writes zero to each of the TILE_W*TILE_H RAM entries, one per
// cycle, and no word is taken meanwhile. A draw first runs its setup products
// on the shared 32-bit multiplier, then steps over the clipped box, one pixel
// per cycle where a pixel is not covered; a covered pixel waits for the
// bit-serial depth divider and the RAM read-modify-write. A pixel read makes
// one RAM read, and a coarse block one RAM read per pixel inside the tile.
module tile_depth_rasterizer_core #(
    parameter int TILE_W   = tdr_pkg::TILE_W_DEF,
    parameter int TILE_H   = tdr_pkg::TILE_H_DEF,
    parameter int COARSE_W = tdr_pkg::COARSE_W_DEF,
    parameter int COARSE_H = tdr_pkg::COARSE_H_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_tile_col,
    input  logic [7:0]  i_tile_row,
    input  logic signed [15:0] i_vx0,
    input  logic signed [15:0] i_vy0,
    input  logic signed [15:0] i_vx1,
    input  logic signed [15:0] i_vy1,
    input  logic signed [15:0] i_vx2,
    input  logic signed [15:0] i_vy2,
    input  logic [24:0] i_vz0,
    input  logic [24:0] i_vz1,
    input  logic [24:0] i_vz2,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_triangle_drawn,
    output logic [24:0] o_read_depth,
    output logic [24:0] o_block_min,
    output logic [24:0] o_block_max
);

`include "tile_depth_rasterizer_core_defines.svh"

    localparam int DEPTH = TILE_W * TILE_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int LXW   = $clog2(TILE_W);
    localparam int LYW   = $clog2(TILE_H);
    localparam int CIW   = $clog2(COARSE_W);
    localparam int CJW   = $clog2(COARSE_H);
    localparam int CW    = tdr_pkg::CRD_W;
    localparam int DW    = tdr_pkg::DEPTH_W;
    localparam int SW    = tdr_pkg::Q_W;
    localparam int BW    = 24;
    localparam logic [DW-1:0] ONE = tdr_pkg::DEPTH_ONE;

    tdr_pkg::t_state r_state, n_state;
    tdr_pkg::t_mode  r_mode;

    logic [tdr_pkg::ORG_W-1:0] r_ox, r_oy;
    logic [tdr_pkg::SCR_W-1:0] r_sw, r_sh;

    logic signed [15:0] r_vx [3];
    logic signed [15:0] r_vy [3];
    logic [DW-1:0]      r_z0;
    logic signed [25:0] r_dz1, r_dz2;
    logic signed [CW-1:0] r_sx, r_sy, r_ex, r_ey;
    logic signed [CW-1:0] r_c, r_r;

    logic [3:0]  r_k;
    logic [31:0] r_prod;
    logic        r_psub;
    tdr_pkg::t_acc r_ptgt;
    logic        r_pv;
    logic [31:0] r_area;
    logic [31:0] r_e [3];
    logic [31:0] r_erow [3];
    logic signed [tdr_pkg::NUM_W-1:0] r_p1, r_p2;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;
    logic [AW-1:0] r_cnt;
    logic          r_clr_res;
    logic          r_drawn;
    logic          r_rd_in;
    logic [DW-1:0] r_bmin, r_bmax;
    logic [CIW-1:0] r_bi;
    logic [CJW-1:0] r_bj;
    logic [BW-1:0] r_bx, r_by;
    logic          r_bv;

    logic          r_ovalid;
    logic          r_o_drawn;
    logic [DW-1:0] r_o_rdepth, r_o_bmin, r_o_bmax;

    logic          w_acc_in;
    logic          w_mem_we, w_mem_re;
    logic [AW-1:0] w_mem_addr;
    logic [DW-1:0] w_mem_wdata;
    logic          w_div_start, w_div_done;
    logic signed [SW-1:0] w_quo;
    logic          w_out_load;
    logic          w_adv;

    logic [31:0] w_ux [3];
    logic [31:0] w_uy [3];
    logic [31:0] w_a [3];
    logic [31:0] w_b [3];
    logic [31:0] w_sx32, w_sy32;
    logic [31:0] w_opa, w_opb, w_sprod;
    logic        w_sub;
    tdr_pkg::t_acc w_tgt;

    logic signed [CW-1:0] w_minx, w_miny, w_maxx, w_maxy;
    logic signed [CW-1:0] w_ox, w_oy, w_texe, w_teye;
    logic signed [CW-1:0] w_bsx, w_bsy, w_bex, w_bey;
    logic [15:0] w_oxp, w_oyp;

    logic signed [CW-1:0] w_lx, w_ly;
    logic        w_xin, w_yin, w_cov, w_clast, w_rlast;
    logic [AW-1:0] w_eaddr, w_raddr, w_baddr;
    logic [BW-1:0] w_blx, w_bly;
    logic        w_bin, w_blast;
    logic signed [tdr_pkg::NUM_W-1:0] w_p1, w_p2, w_num;
    logic signed [SW-1:0] w_d;
    logic [DW-1:0] w_dc;
    logic        w_area_pos, w_box_ok;

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= tdr_pkg::SCR_W_RST;
            r_sh <= tdr_pkg::SCR_H_RST;
        end else if (psel && penable && pwrite) begin
            unique case (tdr_pkg::t_reg'(paddr[2]))
                tdr_pkg::REG_SCREEN_W: r_sw <= pwdata[tdr_pkg::SCR_W-1:0];
                tdr_pkg::REG_SCREEN_H: r_sh <= pwdata[tdr_pkg::SCR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (tdr_pkg::t_reg'(paddr[2]))
            tdr_pkg::REG_SCREEN_W: prdata = 32'(r_sw);
            tdr_pkg::REG_SCREEN_H: prdata = 32'(r_sh);
            default:               prdata = '0;
        endcase
    end

    assign o_in_ready = (r_state == tdr_pkg::S_IDLE);
    assign w_acc_in   = i_in_valid && o_in_ready;

    // Bounding box at acceptance.
    always_comb begin
        w_minx = CW'(i_vx0);
        if (CW'(i_vx1) < w_minx) w_minx = CW'(i_vx1);
        if (CW'(i_vx2) < w_minx) w_minx = CW'(i_vx2);
        w_miny = CW'(i_vy0);
        if (CW'(i_vy1) < w_miny) w_miny = CW'(i_vy1);
        if (CW'(i_vy2) < w_miny) w_miny = CW'(i_vy2);
        w_maxx = CW'(i_vx0);
        if (CW'(i_vx1) > w_maxx) w_maxx = CW'(i_vx1);
        if (CW'(i_vx2) > w_maxx) w_maxx = CW'(i_vx2);
        w_maxy = CW'(i_vy0);
        if (CW'(i_vy1) > w_maxy) w_maxy = CW'(i_vy1);
        if (CW'(i_vy2) > w_maxy) w_maxy = CW'(i_vy2);
        w_ox   = $signed(CW'(r_ox));
        w_oy   = $signed(CW'(r_oy));
        w_texe = $signed(CW'(r_ox) + CW'(TILE_W));
        if ($signed(CW'(r_sw)) < w_texe) w_texe = $signed(CW'(r_sw));
        w_teye = $signed(CW'(r_oy) + CW'(TILE_H));
        if ($signed(CW'(r_sh)) < w_teye) w_teye = $signed(CW'(r_sh));
        w_bsx = (w_minx < w_ox) ? w_ox : w_minx;
        w_bsx = {w_bsx[CW-1:1], 1'b0};
        w_bsy = (w_miny < w_oy) ? w_oy : w_miny;
        w_bsy = {w_bsy[CW-1:1], 1'b0};
        w_bex = (w_maxx > w_texe) ? w_texe : w_maxx;
        w_bey = (w_maxy > w_teye) ? w_teye : w_maxy;
        w_oxp = 16'(i_tile_col) * 16'(TILE_W);
        w_oyp = 16'(i_tile_row) * 16'(TILE_H);
    end

    // Edge coefficients, all modulo two to the 32.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ux[i] = {{16{r_vx[i][15]}}, r_vx[i]};
            w_uy[i] = {{16{r_vy[i][15]}}, r_vy[i]};
        end
        w_a[0] = w_uy[1] - w_uy[2];
        w_a[1] = w_uy[2] - w_uy[0];
        w_a[2] = w_uy[0] - w_uy[1];
        w_b[0] = w_ux[2] - w_ux[1];
        w_b[1] = w_ux[0] - w_ux[2];
        w_b[2] = w_ux[1] - w_ux[0];
        w_sx32 = {{(32-CW){r_sx[CW-1]}}, r_sx};
        w_sy32 = {{(32-CW){r_sy[CW-1]}}, r_sy};
    end

    // Setup sequence on the shared multiplier.
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_sub = 1'b0;
        w_tgt = tdr_pkg::ACC_AREA;
        case (r_k)
            4'd0:  begin w_opa = w_b[2]; w_opb = w_a[1]; end
            4'd1:  begin w_opa = w_b[1]; w_opb = w_a[2]; w_sub = 1'b1; end
            4'd2:  begin w_opa = w_ux[1]; w_opb = w_uy[2]; w_tgt = tdr_pkg::ACC_E0; end
            4'd3:  begin
                w_opa = w_ux[2]; w_opb = w_uy[1]; w_sub = 1'b1; w_tgt = tdr_pkg::ACC_E0;
            end
            4'd4:  begin w_opa = w_a[0]; w_opb = w_sx32; w_tgt = tdr_pkg::ACC_E0; end
            4'd5:  begin w_opa = w_b[0]; w_opb = w_sy32; w_tgt = tdr_pkg::ACC_E0; end
            4'd6:  begin w_opa = w_ux[2]; w_opb = w_uy[0]; w_tgt = tdr_pkg::ACC_E1; end
            4'd7:  begin
                w_opa = w_ux[0]; w_opb = w_uy[2]; w_sub = 1'b1; w_tgt = tdr_pkg::ACC_E1;
            end
            4'd8:  begin w_opa = w_a[1]; w_opb = w_sx32; w_tgt = tdr_pkg::ACC_E1; end
            4'd9:  begin w_opa = w_b[1]; w_opb = w_sy32; w_tgt = tdr_pkg::ACC_E1; end
            4'd10: begin w_opa = w_ux[0]; w_opb = w_uy[1]; w_tgt = tdr_pkg::ACC_E2; end
            4'd11: begin
                w_opa = w_ux[1]; w_opb = w_uy[0]; w_sub = 1'b1; w_tgt = tdr_pkg::ACC_E2;
            end
            4'd12: begin w_opa = w_a[2]; w_opb = w_sx32; w_tgt = tdr_pkg::ACC_E2; end
            4'd13: begin w_opa = w_b[2]; w_opb = w_sy32; w_tgt = tdr_pkg::ACC_E2; end
            default: ;
        endcase
        w_sprod = w_opa * w_opb;
    end

    // Pixel walk.
    always_comb begin
        w_lx    = r_c - w_ox;
        w_ly    = r_r - w_oy;
        w_xin   = !w_lx[CW-1] && (w_lx[CW-2:0] < (CW-1)'(TILE_W));
        w_yin   = !w_ly[CW-1] && (w_ly[CW-2:0] < (CW-1)'(TILE_H));
        w_cov   = w_xin && w_yin && !r_e[0][31] && !r_e[1][31] && !r_e[2][31];
        w_clast = (r_c + CW'(1)) >= r_ex;
        w_rlast = (r_r + CW'(1)) >= r_ey;
        w_eaddr = AW'(w_ly[LYW-1:0]) * AW'(TILE_H > 0 ? TILE_W : 1) + AW'(w_lx[LXW-1:0]);
        w_raddr = AW'(r_vy[0][LYW-1:0]) * AW'(TILE_W) + AW'(r_vx[0][LXW-1:0]);
        w_blx   = r_bx + BW'(r_bi);
        w_bly   = r_by + BW'(r_bj);
        w_bin   = (w_blx < BW'(TILE_W)) && (w_bly < BW'(TILE_H));
        w_baddr = AW'(w_bly[LYW-1:0]) * AW'(TILE_W) + AW'(w_blx[LXW-1:0]);
        w_blast = (r_bi == CIW'(COARSE_W - 1)) && (r_bj == CJW'(COARSE_H - 1));
        w_p1    = r_dz1 * $signed(r_e[1]);
        w_p2    = r_dz2 * $signed(r_e[2]);
        w_num   = r_p1 + r_p2;
        w_d     = $signed(SW'(r_z0)) + w_quo;
        if (w_d[SW-1]) begin
            w_dc = '0;
        end else if (w_d > $signed(SW'(ONE))) begin
            w_dc = ONE;
        end else begin
            w_dc = w_d[DW-1:0];
        end
        w_area_pos = !r_area[31] && (r_area != '0);
        w_box_ok   = (r_ex > r_sx) && (r_ey > r_sy);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdr_pkg::S_CLEAR: begin
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_state = r_clr_res ? tdr_pkg::S_OUT : tdr_pkg::S_IDLE;
                end
            end
            tdr_pkg::S_IDLE: begin
                if (w_acc_in) begin
                    unique case (tdr_pkg::t_mode'(i_mode))
                        tdr_pkg::MODE_CLEAR: n_state = tdr_pkg::S_CLEAR;
                        tdr_pkg::MODE_DRAW:  n_state = tdr_pkg::S_SETUP;
                        tdr_pkg::MODE_READ:  n_state = tdr_pkg::S_READ;
                        tdr_pkg::MODE_BLOCK: n_state = tdr_pkg::S_BLOCK;
                        default:             n_state = tdr_pkg::S_IDLE;
                    endcase
                end
            end
            tdr_pkg::S_SETUP: begin
                if (r_k == 4'd14) n_state = tdr_pkg::S_CHECK;
            end
            tdr_pkg::S_CHECK: begin
                n_state = (w_area_pos && w_box_ok) ? tdr_pkg::S_EDGE : tdr_pkg::S_OUT;
            end
            tdr_pkg::S_EDGE: begin
                if (w_cov) begin
                    n_state = tdr_pkg::S_MUL;
                end else if (w_clast && w_rlast) begin
                    n_state = tdr_pkg::S_OUT;
                end
            end
            tdr_pkg::S_MUL:  n_state = tdr_pkg::S_NUM;
            tdr_pkg::S_NUM:  n_state = tdr_pkg::S_DIV;
            tdr_pkg::S_DIV: begin
                if (w_div_done) n_state = tdr_pkg::S_WB;
            end
            tdr_pkg::S_WB: begin
                n_state = (w_clast && w_rlast) ? tdr_pkg::S_OUT : tdr_pkg::S_EDGE;
            end
            tdr_pkg::S_READ:  n_state = tdr_pkg::S_OUT;
            tdr_pkg::S_BLOCK: begin
                if (w_blast) n_state = tdr_pkg::S_BDRAIN;
            end
            tdr_pkg::S_BDRAIN: n_state = tdr_pkg::S_OUT;
            tdr_pkg::S_OUT: begin
                if (!r_ovalid || i_out_ready) n_state = tdr_pkg::S_IDLE;
            end
            default: n_state = tdr_pkg::S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = r_cnt;
        w_mem_wdata = '0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        w_adv       = 1'b0;
        unique case (r_state)
            tdr_pkg::S_CLEAR: begin
                w_mem_we = 1'b1;
            end
            tdr_pkg::S_EDGE: begin
                w_mem_re   = w_cov;
                w_mem_addr = w_eaddr;
                w_adv      = !w_cov;
            end
            tdr_pkg::S_NUM: begin
                w_div_start = 1'b1;
            end
            tdr_pkg::S_WB: begin
                w_mem_we    = (w_dc > r_rdata);
                w_mem_addr  = w_eaddr;
                w_mem_wdata = w_dc;
                w_adv       = 1'b1;
            end
            tdr_pkg::S_READ: begin
                w_mem_re   = 1'b1;
                w_mem_addr = w_raddr;
            end
            tdr_pkg::S_BLOCK: begin
                w_mem_re   = w_bin;
                w_mem_addr = w_baddr;
            end
            tdr_pkg::S_OUT: begin
                w_out_load = !r_ovalid || i_out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdr_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Depth RAM.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[w_mem_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_clr_res <= 1'b0;
            r_ox      <= '0;
            r_oy      <= '0;
            r_pv      <= 1'b0;
            r_bv      <= 1'b0;
        end else begin
            r_pv <= (r_state == tdr_pkg::S_SETUP) && (r_k != 4'd14);
            r_bv <= (r_state == tdr_pkg::S_BLOCK) && w_bin;
            if (r_state == tdr_pkg::S_CLEAR) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (w_acc_in) begin
                r_clr_res <= (tdr_pkg::t_mode'(i_mode) == tdr_pkg::MODE_CLEAR);
                r_cnt     <= '0;
                if (tdr_pkg::t_mode'(i_mode) == tdr_pkg::MODE_CLEAR) begin
                    r_ox <= (w_oxp > 16'd4095) ? '1 : w_oxp[tdr_pkg::ORG_W-1:0];
                    r_oy <= (w_oyp > 16'd4095) ? '1 : w_oyp[tdr_pkg::ORG_W-1:0];
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_mode  <= tdr_pkg::t_mode'(i_mode);
            r_vx[0] <= i_vx0;
            r_vx[1] <= i_vx1;
            r_vx[2] <= i_vx2;
            r_vy[0] <= i_vy0;
            r_vy[1] <= i_vy1;
            r_vy[2] <= i_vy2;
            r_z0    <= i_vz0;
            r_dz1   <= $signed({1'b0, i_vz1}) - $signed({1'b0, i_vz0});
            r_dz2   <= $signed({1'b0, i_vz2}) - $signed({1'b0, i_vz0});
            r_sx    <= w_bsx;
            r_sy    <= w_bsy;
            r_ex    <= w_bex;
            r_ey    <= w_bey;
            r_k     <= '0;
            r_area  <= '0;
            r_e[0]  <= '0;
            r_e[1]  <= '0;
            r_e[2]  <= '0;
            r_drawn <= 1'b0;
            r_rd_in <= ({1'b0, i_vx0} < 17'(TILE_W)) && ({1'b0, i_vy0} < 17'(TILE_H));
            r_bx    <= BW'({1'b0, i_vx0}) * BW'(COARSE_W);
            r_by    <= BW'({1'b0, i_vy0}) * BW'(COARSE_H);
            r_bi    <= '0;
            r_bj    <= '0;
            r_bmin  <= ONE;
            r_bmax  <= '0;
        end

        if (r_state == tdr_pkg::S_SETUP) begin
            r_prod <= w_sprod;
            r_psub <= w_sub;
            r_ptgt <= w_tgt;
            r_k    <= r_k + 4'd1;
        end
        if (r_pv) begin
            case (r_ptgt)
                tdr_pkg::ACC_AREA: r_area <= r_psub ? r_area - r_prod : r_area + r_prod;
                tdr_pkg::ACC_E0:   r_e[0] <= r_psub ? r_e[0] - r_prod : r_e[0] + r_prod;
                tdr_pkg::ACC_E1:   r_e[1] <= r_psub ? r_e[1] - r_prod : r_e[1] + r_prod;
                default:           r_e[2] <= r_psub ? r_e[2] - r_prod : r_e[2] + r_prod;
            endcase
        end

        if (r_state == tdr_pkg::S_CHECK) begin
            r_drawn <= w_area_pos && w_box_ok;
            r_c     <= r_sx;
            r_r     <= r_sy;
            for (int i = 0; i < 3; i++) begin
                r_erow[i] <= r_e[i];
            end
        end

        if (w_adv) begin
            if (!w_clast) begin
                r_c <= r_c + CW'(1);
                for (int i = 0; i < 3; i++) begin
                    r_e[i] <= r_e[i] + w_a[i];
                end
            end else begin
                r_c <= r_sx;
                r_r <= r_r + CW'(1);
                for (int i = 0; i < 3; i++) begin
                    r_erow[i] <= r_erow[i] + w_b[i];
                    r_e[i]    <= r_erow[i] + w_b[i];
                end
            end
        end

        if (r_state == tdr_pkg::S_MUL) begin
            r_p1 <= w_p1;
            r_p2 <= w_p2;
        end

        if (r_state == tdr_pkg::S_BLOCK) begin
            if (r_bi == CIW'(COARSE_W - 1)) begin
                r_bi <= '0;
                r_bj <= r_bj + CJW'(1);
            end else begin
                r_bi <= r_bi + CIW'(1);
            end
        end
        if (r_bv) begin
            if (r_rdata < r_bmin) r_bmin <= r_rdata;
            if (r_rdata > r_bmax) r_bmax <= r_rdata;
        end
    end

    tdr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_area[30:0]),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_drawn  <= (r_mode == tdr_pkg::MODE_DRAW) && r_drawn;
            r_o_rdepth <= ((r_mode == tdr_pkg::MODE_READ) && r_rd_in) ? r_rdata : '0;
            r_o_bmin   <= (r_mode == tdr_pkg::MODE_BLOCK) ? r_bmin : '0;
            r_o_bmax   <= (r_mode == tdr_pkg::MODE_BLOCK) ? r_bmax : '0;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_triangle_drawn = r_o_drawn;
    assign o_read_depth     = r_o_rdepth;
    assign o_block_min      = r_o_bmin;
    assign o_block_max      = r_o_bmax;

    `TDR_ASSERT_NOW(a_ram_write_state, w_mem_we,
        (r_state == tdr_pkg::S_CLEAR) || (r_state == tdr_pkg::S_WB),
        "RAM write outside clearing pass or write-back")
    `TDR_ASSERT_NOW(a_div_done_state, w_div_done, r_state == tdr_pkg::S_DIV,
        "divider finished while the sequencer was not waiting for it")
    `TDR_ASSERT_NEXT(a_out_load_valid, w_out_load, o_out_valid,
        "loaded result word not presented")

endmodule

// ----- dv/tb_tile_depth_rasterizer_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tile depth rasterizer core testbench
// Streams tile selections, triangles, pixel reads and coarse block queries
// into the core under random gaps on both channels, predicts every result
// word with a behavioral copy of the tile store and compares field by field.
// ---------------------------------------------------------------------------
module tb_tile_depth_rasterizer_core;

    localparam int TW = tdr_pkg::TILE_W_DEF;
    localparam int TH = tdr_pkg::TILE_H_DEF;
    localparam int CW = tdr_pkg::COARSE_W_DEF;
    localparam int CH = tdr_pkg::COARSE_H_DEF;
    localparam int IDLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 1100;

    typedef struct {
        tdr_pkg::t_mode     mode;
        logic [7:0]         tile_col;
        logic [7:0]         tile_row;
        logic signed [15:0] vx0, vy0, vx1, vy1, vx2, vy2;
        logic [24:0]        vz0, vz1, vz2;
    } t_word_in;

    typedef struct {
        logic        drawn;
        logic [24:0] depth;
        logic [24:0] bmin;
        logic [24:0] bmax;
    } t_word_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        o_in_ready;
    logic [1:0]  mode;
    logic [7:0]  tile_col, tile_row;
    logic signed [15:0] vx0, vy0, vx1, vy1, vx2, vy2;
    logic [24:0] vz0, vz1, vz2;
    logic        o_out_valid;
    logic        out_ready;
    logic        o_triangle_drawn;
    logic [24:0] o_read_depth, o_block_min, o_block_max;

    tile_depth_rasterizer_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready),
        .i_mode(mode), .i_tile_col(tile_col), .i_tile_row(tile_row),
        .i_vx0(vx0), .i_vy0(vy0), .i_vx1(vx1), .i_vy1(vy1),
        .i_vx2(vx2), .i_vy2(vy2),
        .i_vz0(vz0), .i_vz1(vz1), .i_vz2(vz2),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready),
        .o_triangle_drawn(o_triangle_drawn), .o_read_depth(o_read_depth),
        .o_block_min(o_block_min), .o_block_max(o_block_max)
    );

    t_word_in  pending_words[$];
    t_word_out expected_words[$];
    t_word_in  drive_word;

    logic [24:0] depth_store [TW*TH];
    int          org_x, org_y;
    int          scr_w, scr_h;
    int          gen_ox, gen_oy;
    int          errors;
    int          in_gap, out_stall;
    bit          no_idle;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_word_out rasterize_word(t_word_in w);
        t_word_out r;
        bit [31:0] ux0, uy0, ux1, uy1, ux2, uy2, t;
        bit [31:0] a0, a1, a2, b0, b1, b2, c0, c1, c2, al, be, ga;
        longint area, z0, dz1, dz2, num, q, d;
        int x0, y0, x1, y1, x2, y2, tex, tey, sx, sy, ex, ey, lx, ly, bx, by, mn, mx;
        r = '{default: '0};
        case (w.mode)
            tdr_pkg::MODE_CLEAR: begin
                org_x = int'(w.tile_col) * TW;
                org_y = int'(w.tile_row) * TH;
                if (org_x > 4095) org_x = 4095;
                if (org_y > 4095) org_y = 4095;
                foreach (depth_store[i]) depth_store[i] = '0;
            end
            tdr_pkg::MODE_DRAW: begin
                x0 = w.vx0; y0 = w.vy0; x1 = w.vx1; y1 = w.vy1; x2 = w.vx2; y2 = w.vy2;
                ux0 = x0; uy0 = y0; ux1 = x1; uy1 = y1; ux2 = x2; uy2 = y2;
                z0 = w.vz0;
                dz1 = longint'(w.vz1) - z0;
                dz2 = longint'(w.vz2) - z0;
                t = (ux1 - ux0) * (uy2 - uy0) - (ux0 - ux2) * (uy0 - uy1);
                area = longint'(int'(t));
                if (area > 0) begin
                    tex = org_x + TW - 1;
                    tey = org_y + TH - 1;
                    if (tex > scr_w - 1) tex = scr_w - 1;
                    if (tey > scr_h - 1) tey = scr_h - 1;
                    sx = x0 < x1 ? x0 : x1; sx = sx < x2 ? sx : x2;
                    sy = y0 < y1 ? y0 : y1; sy = sy < y2 ? sy : y2;
                    ex = x0 > x1 ? x0 : x1; ex = ex > x2 ? ex : x2;
                    ey = y0 > y1 ? y0 : y1; ey = ey > y2 ? ey : y2;
                    if (sx < org_x) sx = org_x;
                    if (sy < org_y) sy = org_y;
                    if (ex > tex + 1) ex = tex + 1;
                    if (ey > tey + 1) ey = tey + 1;
                    sx = sx - (sx & 1);
                    sy = sy - (sy & 1);
                    if (ex > sx && ey > sy) begin
                        r.drawn = 1'b1;
                        a0 = uy1 - uy2; a1 = uy2 - uy0; a2 = uy0 - uy1;
                        b0 = ux2 - ux1; b1 = ux0 - ux2; b2 = ux1 - ux0;
                        c0 = ux1 * uy2 - ux2 * uy1;
                        c1 = ux2 * uy0 - ux0 * uy2;
                        c2 = ux0 * uy1 - ux1 * uy0;
                        for (int row = sy; row < ey; row++) begin
                            ly = row - org_y;
                            if (ly < 0 || ly >= TH) continue;
                            for (int col = sx; col < ex; col++) begin
                                lx = col - org_x;
                                if (lx < 0 || lx >= TW) continue;
                                al = a0 * 32'(col) + b0 * 32'(row) + c0;
                                be = a1 * 32'(col) + b1 * 32'(row) + c1;
                                ga = a2 * 32'(col) + b2 * 32'(row) + c2;
                                if ((al[31] | be[31] | ga[31]) != 1'b0) continue;
                                num = dz1 * longint'(int'(be)) + dz2 * longint'(int'(ga));
                                q = num / area;
                                if (num < 0 && q * area != num) q = q - 1;
                                d = z0 + q;
                                if (d < 0) d = 0;
                                if (d > longint'(tdr_pkg::DEPTH_ONE)) d = tdr_pkg::DEPTH_ONE;
                                if (25'(d) > depth_store[ly*TW + lx])
                                    depth_store[ly*TW + lx] = 25'(d);
                            end
                        end
                    end
                end
            end
            tdr_pkg::MODE_READ: begin
                lx = int'(unsigned'(w.vx0));
                ly = int'(unsigned'(w.vy0));
                if (lx < TW && ly < TH) r.depth = depth_store[ly*TW + lx];
            end
            default: begin
                bx = int'(unsigned'(w.vx0)) * CW;
                by = int'(unsigned'(w.vy0)) * CH;
                mn = tdr_pkg::DEPTH_ONE;
                mx = 0;
                for (int j = 0; j < CH; j++) begin
                    if (by + j >= TH) break;
                    for (int i = 0; i < CW; i++) begin
                        if (bx + i >= TW) break;
                        if (depth_store[(by+j)*TW + bx + i] < mn)
                            mn = depth_store[(by+j)*TW + bx + i];
                        if (depth_store[(by+j)*TW + bx + i] > mx)
                            mx = depth_store[(by+j)*TW + bx + i];
                    end
                end
                r.bmin = 25'(mn);
                r.bmax = 25'(mx);
            end
        endcase
        return r;
    endfunction

    // Driver: presents queued words and records the prediction on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (in_valid && o_in_ready)
                expected_words.push_back(rasterize_word(drive_word));
            if (!in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    drive_word = pending_words.pop_front();
                    mode <= drive_word.mode;
                    tile_col <= drive_word.tile_col;
                    tile_row <= drive_word.tile_row;
                    vx0 <= drive_word.vx0; vy0 <= drive_word.vy0;
                    vx1 <= drive_word.vx1; vy1 <= drive_word.vy1;
                    vx2 <= drive_word.vx2; vy2 <= drive_word.vy2;
                    vz0 <= drive_word.vz0; vz1 <= drive_word.vz1; vz2 <= drive_word.vz2;
                    in_valid <= 1'b1;
                    in_gap <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_word_out e;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word", $time);
                    errors++;
                end else begin
                    e = expected_words.pop_front();
                    if (o_triangle_drawn !== e.drawn) begin
                        $display("%0t: triangle_drawn expected %0d actual %0d",
                                 $time, e.drawn, o_triangle_drawn);
                        errors++;
                    end
                    if (o_read_depth !== e.depth) begin
                        $display("%0t: read_depth expected %0h actual %0h",
                                 $time, e.depth, o_read_depth);
                        errors++;
                    end
                    if (o_block_min !== e.bmin) begin
                        $display("%0t: block_min expected %0h actual %0h",
                                 $time, e.bmin, o_block_min);
                        errors++;
                    end
                    if (o_block_max !== e.bmax) begin
                        $display("%0t: block_max expected %0h actual %0h",
                                 $time, e.bmax, o_block_max);
                        errors++;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                out_stall <= pick_gap();
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        int idle_cycles;
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
            || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(tdr_pkg::t_reg idx, int value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(int'(idx) * 4);
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == tdr_pkg::REG_SCREEN_W) scr_w = value & 32'h1FFF;
        else scr_h = value & 32'h1FFF;
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_word_in blank_word(tdr_pkg::t_mode m);
        t_word_in w;
        w = '{mode: m, default: '0};
        return w;
    endfunction

    task automatic push_clear(int col, int row);
        t_word_in w;
        w = blank_word(tdr_pkg::MODE_CLEAR);
        w.tile_col = 8'(col);
        w.tile_row = 8'(row);
        gen_ox = col * TW > 4095 ? 4095 : col * TW;
        gen_oy = row * TH > 4095 ? 4095 : row * TH;
        pending_words.push_back(w);
    endtask

    task automatic push_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                            int z0, int z1, int z2);
        t_word_in w;
        w = blank_word(tdr_pkg::MODE_DRAW);
        w.vx0 = 16'(x0); w.vy0 = 16'(y0);
        w.vx1 = 16'(x1); w.vy1 = 16'(y1);
        w.vx2 = 16'(x2); w.vy2 = 16'(y2);
        w.vz0 = 25'(z0); w.vz1 = 25'(z1); w.vz2 = 25'(z2);
        pending_words.push_back(w);
    endtask

    task automatic push_query(tdr_pkg::t_mode m, int x, int y);
        t_word_in w;
        w = blank_word(m);
        w.vx0 = 16'(x);
        w.vy0 = 16'(y);
        pending_words.push_back(w);
    endtask

    function automatic int rand_depth();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, tdr_pkg::DEPTH_ONE);
        return $urandom & 32'h1FFFFFF;
    endfunction

    task automatic push_random();
        t_word_in w;
        int p, bx, by, s;
        p = $urandom_range(0, 99);
        if (p < 7) begin
            if ($urandom_range(0, 1) == 0) push_clear($urandom_range(0, 255), $urandom_range(0, 255));
            else push_clear($urandom_range(0, (scr_w - 1) / TW), $urandom_range(0, (scr_h - 1) / TH));
        end else if (p < 57) begin
            s = $urandom_range(0, 99) < 92 ? 10 : 40;
            bx = gen_ox + $urandom_range(0, TW + 8) - 4;
            by = gen_oy + $urandom_range(0, TH + 8) - 4;
            push_tri(bx + $urandom_range(0, 2*s) - s, by + $urandom_range(0, 2*s) - s,
                     bx + $urandom_range(0, 2*s) - s, by + $urandom_range(0, 2*s) - s,
                     bx + $urandom_range(0, 2*s) - s, by + $urandom_range(0, 2*s) - s,
                     rand_depth(), rand_depth(), rand_depth());
        end else if (p < 77) begin
            if ($urandom_range(0, 9) == 0) push_query(tdr_pkg::MODE_READ, $urandom, $urandom);
            else push_query(tdr_pkg::MODE_READ, $urandom_range(0, TW + 1),
                            $urandom_range(0, TH + 1));
        end else if (p < 93) begin
            if ($urandom_range(0, 9) == 0) push_query(tdr_pkg::MODE_BLOCK, $urandom, $urandom);
            else push_query(tdr_pkg::MODE_BLOCK, $urandom_range(0, TW / CW),
                            $urandom_range(0, TH / CH));
        end else begin
            w.mode = tdr_pkg::t_mode'($urandom_range(1, 3));
            w.tile_col = 8'($urandom); w.tile_row = 8'($urandom);
            w.vx0 = 16'($urandom); w.vy0 = 16'($urandom);
            w.vx1 = 16'($urandom); w.vy1 = 16'($urandom);
            w.vx2 = 16'($urandom); w.vy2 = 16'($urandom);
            w.vz0 = 25'($urandom); w.vz1 = 25'($urandom); w.vz2 = 25'($urandom);
            pending_words.push_back(w);
        end
    endtask

    initial begin
        int widths[6]  = '{1024, 4096, 1, 4096, 33, 0};
        int heights[6] = '{512, 4096, 1, 17, 45, 0};
        i_clk = 1'b0;
        errors = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; out_ready = 1'b0;
        mode = '0; tile_col = '0; tile_row = '0;
        vx0 = '0; vy0 = '0; vx1 = '0; vy1 = '0; vx2 = '0; vy2 = '0;
        vz0 = '0; vz1 = '0; vz2 = '0;
        scr_w = tdr_pkg::SCR_W_RST; scr_h = tdr_pkg::SCR_H_RST;
        org_x = 0; org_y = 0; gen_ox = 0; gen_oy = 0;
        foreach (depth_store[i]) depth_store[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_reg(tdr_pkg::REG_SCREEN_W,
                          widths[ph] > 0 ? widths[ph] : $urandom_range(1, 4096));
                write_reg(tdr_pkg::REG_SCREEN_H,
                          heights[ph] > 0 ? heights[ph] : $urandom_range(1, 4096));
            end
            no_idle = (ph == 2);
            if (ph == 1) begin
                push_clear(0, 0);
                push_tri(0, 0, 64, 0, 0, 64, 0, tdr_pkg::DEPTH_ONE, tdr_pkg::DEPTH_ONE / 2);
                push_tri(0, 0, 0, 64, 64, 0,
                         tdr_pkg::DEPTH_ONE, tdr_pkg::DEPTH_ONE, tdr_pkg::DEPTH_ONE);
                push_tri(2, 2, 10, 10, 20, 20,
                         tdr_pkg::DEPTH_ONE, tdr_pkg::DEPTH_ONE, tdr_pkg::DEPTH_ONE);
                push_tri(3, 3, 30, 5, 8, 28, 25'h1FFFFFF, 25'h1FFFFFF, 0);
                push_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                         tdr_pkg::DEPTH_ONE, 0, 25'h1FFFFFF);
                push_query(tdr_pkg::MODE_READ, 0, 0);
                push_query(tdr_pkg::MODE_READ, TW - 1, TH - 1);
                push_query(tdr_pkg::MODE_READ, TW, 0);
                push_query(tdr_pkg::MODE_READ, 16'hFFFF, 16'hFFFF);
                push_query(tdr_pkg::MODE_BLOCK, 0, 0);
                push_query(tdr_pkg::MODE_BLOCK, TW / CW - 1, TH / CH - 1);
                push_query(tdr_pkg::MODE_BLOCK, TW / CW, 0);
                push_query(tdr_pkg::MODE_BLOCK, 16'hFFFF, 16'hFFFF);
                // Saturated origin lands on an odd column at the screen edge.
                push_clear(255, 255);
                push_tri(4090, 4090, 4200, 4090, 4090, 4200,
                         tdr_pkg::DEPTH_ONE, tdr_pkg::DEPTH_ONE, tdr_pkg::DEPTH_ONE);
                push_query(tdr_pkg::MODE_READ, 0, 0);
                push_query(tdr_pkg::MODE_BLOCK, 0, 0);
                push_clear(200, 1);
                push_tri(6400, 32, 6500, 32, 6400, 90, tdr_pkg::DEPTH_ONE, 5, 5);
                push_query(tdr_pkg::MODE_READ, 0, 0);
                push_clear(1, 1);
            end
            for (int n = 0; n < 88; n++) push_random();
            wait_idle();
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
